>>> rtl/core/ccx_pkg.sv
// ---------------------------------------------------------------------------
// ccx_pkg
// Shared widths, constants and sequencer states for the cycle counter
// extend and split core.
// ---------------------------------------------------------------------------
`default_nettype none

package ccx_pkg;

    // counter and field widths
    localparam int CCX_COUNTER_WIDTH = 32;
    localparam int CCX_SAMPLE_W      = 32;
    localparam int CCX_WRAP_W        = 32;
    localparam int CCX_TOTAL_W       = 64;
    localparam int CCX_SEC_W         = 45;
    localparam int CCX_FRAC_W        = 10;
    localparam int CCX_FREQ_W        = 10;

    // divisor width: 1023 MHz in Hz stays below 2^30
    localparam int CCX_DIV_W         = 30;

    // conversion constants
    localparam int CCX_HZ_PER_MHZ    = 1000000;
    localparam int CCX_KHZ_PER_MHZ   = 1000;
    localparam int CCX_FRAC_LIMIT    = 1000;

    // step counter covers the longest division pass
    localparam int CCX_CNT_W         = $clog2(CCX_TOTAL_W);

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MS_LOAD,
        ST_MS,
        ST_US_LOAD,
        ST_US,
        ST_OUT
    } t_ccx_state;

endpackage : ccx_pkg

`default_nettype wire

>>> rtl/core/ccx_sample_if.sv
// ---------------------------------------------------------------------------
// ccx_sample_if
// Input channel: one raw cycle counter sample per word.
// ---------------------------------------------------------------------------
`default_nettype none

interface ccx_sample_if import ccx_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [CCX_SAMPLE_W-1:0] counter_sample;

    modport source (output valid, output counter_sample, input ready);
    modport sink   (input valid, input counter_sample, output ready);

endinterface : ccx_sample_if

`default_nettype wire

>>> rtl/core/ccx_result_if.sv
// ---------------------------------------------------------------------------
// ccx_result_if
// Output channel: extended cycle total and its split into time units.
// ---------------------------------------------------------------------------
`default_nettype none

interface ccx_result_if import ccx_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [CCX_TOTAL_W-1:0] total_cycles;
    logic [CCX_SEC_W-1:0]   seconds;
    logic [CCX_FRAC_W-1:0]  milliseconds;
    logic [CCX_FRAC_W-1:0]  microseconds;
    logic                   wrapped;

    modport source (
        output valid, output total_cycles, output seconds,
        output milliseconds, output microseconds, output wrapped,
        input  ready
    );
    modport sink (
        input  valid, input total_cycles, input seconds,
        input  milliseconds, input microseconds, input wrapped,
        output ready
    );

endinterface : ccx_result_if

`default_nettype wire

>>> rtl/core/cycle_counter_extend_and_split_core.sv
// ---------------------------------------------------------------------------
// cycle_counter_extend_and_split_core
// Extends samples of a free-running cycle counter to 64 bits by counting
// wraps, then splits the total into seconds, milliseconds and microseconds
// with one shared restoring divider.
// ---------------------------------------------------------------------------
//
//  channel       dir  handshake      contents
//  ------------  ---  -------------  ------------------------------------------
//  i_sample_if   in   valid/ready    counter_sample
//  o_result_if   out  valid/ready    total_cycles, seconds, milliseconds,
//                                    microseconds, wrapped
//  i_cfg_we      in   write strobe   i_cfg_wdata = core clock in MHz
//
//  One word runs from accept through the divide steps for seconds, a load
//  and the divide steps for milliseconds, a load and the divide steps for
//  microseconds, and a hand-over to the output register. The single
//  subtract/compare unit of the divider means no new word is accepted
//  before that hand-over. With the clock frequency at zero a word is taken and dropped.
//  Reset is synchronous, active low; it clears the frequency, wrap count and
//  last sample. The output register holds its word while o_result_if.ready
//  is low, and the next word is accepted meanwhile; its result waits in the
//  divider until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module cycle_counter_extend_and_split_core import ccx_pkg::*; #(
    parameter int COUNTER_WIDTH = CCX_COUNTER_WIDTH
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    ccx_sample_if.sink           i_sample_if,
    ccx_result_if.source         o_result_if,
    input  wire                  i_cfg_we,
    input  wire [CCX_FREQ_W-1:0] i_cfg_wdata
);

    // control state
    t_ccx_state               r_state, n_state;
    logic [CCX_CNT_W-1:0]     r_cnt, n_cnt;
    logic [CCX_FREQ_W-1:0]    r_freq;
    logic [CCX_WRAP_W-1:0]    r_wrap, n_wrap;
    logic [COUNTER_WIDTH-1:0] r_last, n_last;
    logic                     r_out_valid, n_out_valid;

    // divider and payload
    logic [CCX_DIV_W-1:0]     r_rem, n_rem;
    logic [CCX_TOTAL_W-1:0]   r_quo, n_quo;
    logic [CCX_DIV_W-1:0]     r_div, n_div;
    logic [CCX_TOTAL_W-1:0]   r_total, n_total;
    logic                     r_wrapped, n_wrapped;
    logic [CCX_SEC_W-1:0]     r_seconds, n_seconds;
    logic [CCX_FRAC_W-1:0]    r_ms, n_ms;

    // output register
    logic [CCX_TOTAL_W-1:0]   r_o_total, n_o_total;
    logic [CCX_SEC_W-1:0]     r_o_seconds, n_o_seconds;
    logic [CCX_FRAC_W-1:0]    r_o_ms, n_o_ms;
    logic [CCX_FRAC_W-1:0]    r_o_us, n_o_us;
    logic                     r_o_wrapped, n_o_wrapped;

    // combinational helpers
    logic                     w_accept;
    logic [COUNTER_WIDTH-1:0] w_sample;
    logic                     w_wrap;
    logic [CCX_WRAP_W-1:0]    w_wrap_next;
    logic [CCX_TOTAL_W-1:0]   w_total;
    logic [CCX_DIV_W:0]       w_trial;
    logic                     w_fits;
    logic [CCX_DIV_W-1:0]     w_rem_step;
    logic [CCX_TOTAL_W-1:0]   w_quo_step;
    logic                     w_out_free;

    // handshake
    assign i_sample_if.ready = (r_state == ST_IDLE);
    assign w_accept          = i_sample_if.valid && (r_state == ST_IDLE);
    assign w_out_free        = !r_out_valid || o_result_if.ready;

    assign o_result_if.valid        = r_out_valid;
    assign o_result_if.total_cycles = r_o_total;
    assign o_result_if.seconds      = r_o_seconds;
    assign o_result_if.milliseconds = r_o_ms;
    assign o_result_if.microseconds = r_o_us;
    assign o_result_if.wrapped      = r_o_wrapped;

    // wrap detection and extended total
    assign w_sample    = i_sample_if.counter_sample[COUNTER_WIDTH-1:0];
    assign w_wrap      = (w_sample < r_last);
    assign w_wrap_next = r_wrap + CCX_WRAP_W'(w_wrap);
    assign w_total     = (CCX_TOTAL_W'(w_wrap_next) << COUNTER_WIDTH)
                       | CCX_TOTAL_W'(w_sample);

    // one restoring divide step: shift in next dividend bit, subtract if it fits
    assign w_trial    = {r_rem, r_quo[CCX_TOTAL_W-1]};
    assign w_fits     = (w_trial >= {1'b0, r_div});
    assign w_rem_step = w_fits ? CCX_DIV_W'(w_trial - {1'b0, r_div})
                               : w_trial[CCX_DIV_W-1:0];
    assign w_quo_step = {r_quo[CCX_TOTAL_W-2:0], w_fits};

    // sequencer: next state and datapath loads
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_wrap      = r_wrap;
        n_last      = r_last;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_div       = r_div;
        n_total     = r_total;
        n_wrapped   = r_wrapped;
        n_seconds   = r_seconds;
        n_ms        = r_ms;
        n_o_total   = r_o_total;
        n_o_seconds = r_o_seconds;
        n_o_ms      = r_o_ms;
        n_o_us      = r_o_us;
        n_o_wrapped = r_o_wrapped;
        n_out_valid = r_out_valid && !o_result_if.ready;

        case (r_state)
            ST_IDLE: begin
                // words are dropped while the frequency is not set up
                if (w_accept && (r_freq != '0)) begin
                    n_wrap    = w_wrap_next;
                    n_last    = w_sample;
                    n_total   = w_total;
                    n_wrapped = w_wrap;
                    n_rem     = '0;
                    n_quo     = w_total;
                    n_div     = CCX_DIV_W'(r_freq) * CCX_DIV_W'(CCX_HZ_PER_MHZ);
                    n_cnt     = CCX_CNT_W'(CCX_TOTAL_W - 1);
                    n_state   = ST_SEC;
                end
            end
            ST_SEC: begin
                n_rem = w_rem_step;
                n_quo = w_quo_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_MS_LOAD;
                end
            end
            ST_MS_LOAD: begin
                // quotient fits in ten bits, so the upper remainder bits seed the divider
                n_seconds = r_quo[CCX_SEC_W-1:0];
                n_rem     = r_rem >> CCX_FRAC_W;
                n_quo     = {r_rem[CCX_FRAC_W-1:0], {(CCX_TOTAL_W-CCX_FRAC_W){1'b0}}};
                n_div     = CCX_DIV_W'(r_freq) * CCX_DIV_W'(CCX_KHZ_PER_MHZ);
                n_cnt     = CCX_CNT_W'(CCX_FRAC_W - 1);
                n_state   = ST_MS;
            end
            ST_MS: begin
                n_rem = w_rem_step;
                n_quo = w_quo_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_US_LOAD;
                end
            end
            ST_US_LOAD: begin
                n_ms    = r_quo[CCX_FRAC_W-1:0];
                n_rem   = r_rem >> CCX_FRAC_W;
                n_quo   = {r_rem[CCX_FRAC_W-1:0], {(CCX_TOTAL_W-CCX_FRAC_W){1'b0}}};
                n_div   = CCX_DIV_W'(r_freq);
                n_cnt   = CCX_CNT_W'(CCX_FRAC_W - 1);
                n_state = ST_US;
            end
            ST_US: begin
                n_rem = w_rem_step;
                n_quo = w_quo_step;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // hand the word over once the output register is free
                if (w_out_free) begin
                    n_o_total   = r_total;
                    n_o_seconds = r_seconds;
                    n_o_ms      = r_ms;
                    n_o_us      = r_quo[CCX_FRAC_W-1:0];
                    n_o_wrapped = r_wrapped;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_freq      <= '0;
            r_wrap      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_wrap      <= n_wrap;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_freq <= i_cfg_wdata;
            end
        end
    end

    // datapath and output registers
    always_ff @(posedge i_clk) begin
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_div       <= n_div;
        r_total     <= n_total;
        r_wrapped   <= n_wrapped;
        r_seconds   <= n_seconds;
        r_ms        <= n_ms;
        r_o_total   <= n_o_total;
        r_o_seconds <= n_o_seconds;
        r_o_ms      <= n_o_ms;
        r_o_us      <= n_o_us;
        r_o_wrapped <= n_o_wrapped;
    end

    // divider partial remainder always stays below the divisor
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEC || r_state == ST_MS || r_state == ST_US) |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");

    // a new output word only comes from the hand-over state
    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (!$past(r_out_valid) || $past(o_result_if.ready)))
        |-> $past(r_state == ST_OUT))
        else $error("output word loaded outside hand-over");

    // split fields stay within one thousand
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_ms < CCX_FRAC_W'(CCX_FRAC_LIMIT))
                     && (r_o_us < CCX_FRAC_W'(CCX_FRAC_LIMIT)))
        else $error("millisecond or microsecond field out of range");

    // a dropped word leaves the wrap state untouched
    a_drop_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_freq == '0)) |=> (r_state == ST_IDLE) && $stable(r_wrap)
                                          && $stable(r_last))
        else $error("word taken while frequency unset changed state");

endmodule : cycle_counter_extend_and_split_core

`default_nettype wire
